FILE: hw/rtl/grid_cell_ray_exit_step_assert.svh
// ---------------------------------------------------------------------------
// Grid cell ray exit step: assertion macros
// Shorthand for clocked assertions that sample on clk_i and are disabled
// while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef GRID_CELL_RAY_EXIT_STEP_ASSERT_SVH
`define GRID_CELL_RAY_EXIT_STEP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCRES_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCRES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/gcres_pkg.sv
// ---------------------------------------------------------------------------
// Grid cell ray exit step: shared package
// Widths, constants, stage payload types and the restoring division step.
// ---------------------------------------------------------------------------
package gcres_pkg;

  localparam int GRID_SIZE = 16;
  localparam int FRAC_BITS = 16;
  localparam int CELL_W    = 4;
  localparam int IDX_W     = 6;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int SLOPE_W   = 32;
  localparam int REM_W     = SLOPE_W;
  localparam int USER_W    = 2;

  // One quotient bit per divider stage.
  localparam int RECIP_STEPS = 2 * FRAC_BITS;
  localparam int EXIT_STEPS  = FRAC_BITS + 1;
  localparam int EXIT_STAGES = EXIT_STEPS + 1;

  localparam int IN_W        = 2 * CELL_W + 2 * FRAC_W + SLOPE_W;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = 2 * IDX_W + 2 * FRAC_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [FRAC_W-1:0]         FRAC_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [SLOPE_W-1:0] SLOPE_MIN  = {1'b1, {(SLOPE_W-1){1'b0}}};
  localparam logic signed [SLOPE_W-1:0] SLOPE_MAX  = {1'b0, {(SLOPE_W-1){1'b1}}};
  localparam logic signed [IDX_W-1:0]   IDX_BELOW  = '1;
  localparam logic signed [IDX_W-1:0]   GRID_LIMIT = IDX_W'(GRID_SIZE);

  // Slope magnitudes at or below these give a reciprocal beyond 32 bits.
  localparam logic [SLOPE_W-1:0] RECIP_POS_LIMIT = SLOPE_W'(1);
  localparam logic [SLOPE_W-1:0] RECIP_NEG_LIMIT = SLOPE_W'(2);

  typedef enum logic [1:0] {
    EDGE_LEFT,
    EDGE_TOP,
    EDGE_RIGHT,
    EDGE_BOTTOM
  } edge_e;

  typedef enum logic [1:0] {
    EXIT_BOTTOM,
    EXIT_RIGHT,
    EXIT_TOP
  } exit_e;

  typedef struct packed {
    logic [CELL_W-1:0] col;
    logic [CELL_W-1:0] row;
    edge_e             side;
  } cell_t;

  // After edge selection: canonical entry height and raw slope.
  typedef struct packed {
    cell_t                     loc;
    logic [FRAC_W-1:0]         y;
    logic signed [SLOPE_W-1:0] slope;
    logic [SLOPE_W-1:0]        mag;
  } front_t;

  // Slope in the canonical left-edge frame.
  typedef struct packed {
    cell_t                     loc;
    logic [FRAC_W-1:0]         y;
    logic signed [SLOPE_W-1:0] slope;
    logic                      sat;
  } canon_t;

  // Exit point in the canonical frame.
  typedef struct packed {
    cell_t             loc;
    exit_e             dir;
    logic [FRAC_W-1:0] x;
    logic [FRAC_W-1:0] y;
    logic              sat;
  } exit_t;

  typedef struct packed {
    logic signed [IDX_W-1:0] col;
    logic signed [IDX_W-1:0] row;
    logic [FRAC_W-1:0]       frac_col;
    logic [FRAC_W-1:0]       frac_row;
    logic                    outside;
    logic                    sat;
  } result_t;

  typedef struct packed {
    logic             q;
    logic [REM_W-1:0] rem;
  } div_step_t;

  // One step of restoring division: shift in a dividend bit, trial subtract.
  function automatic div_step_t div_step(input logic [REM_W-1:0] rem,
                                         input logic             bit_in,
                                         input logic [REM_W-1:0] den);
    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    div_step_t      res;
    trial   = {rem, bit_in};
    diff    = trial - {1'b0, den};
    res.q   = (trial >= {1'b0, den});
    res.rem = res.q ? diff[REM_W-1:0] : trial[REM_W-1:0];
    return res;
  endfunction

endpackage

FILE: hw/rtl/grid_cell_ray_exit_step.sv
// ---------------------------------------------------------------------------
// Grid cell ray exit step
// Finds where a straight line leaves a unit grid cell and reports the entry
// point in the neighbouring cell.
// ---------------------------------------------------------------------------
// A request carries a cell index, a point on the cell's edge (unsigned Q1.16,
// 65536 being exactly one) and the line's slope (signed Q16.16). The block
// accepts one request in every clock cycle while the output side is not
// stalled and returns one result for each, in order. It picks the entry
// edge, forms one over the slope magnitude in the pipelined divider, turns
// the quotient into the clamped -1/slope for top and bottom entries,
// chooses the exit edge, finds the exit position in a second pipelined
// divider and holds the result in the output register. Each divider stage
// produces one quotient bit, which sets the depth. Every stage carries its
// own valid bit and loads whenever it is empty or its successor moves on, so
// empty slots close up behind a stalled output and requests keep being taken
// until the pipeline is full. The result gives the new cell index (which may
// be -1 or 16), the entry fractions in that cell, a flag for a cell outside
// the 16 by 16 grid, and a flag for a clamped reciprocal or quotient.
// Fractions above one are taken as one; a point that lies on no edge is
// treated as lying on the left edge.
// ---------------------------------------------------------------------------
`include "grid_cell_ray_exit_step_assert.svh"

module grid_cell_ray_exit_step import gcres_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // cell_col[3:0], cell_row[7:4], frac_col[24:8], frac_row[41:25],
  // cell_slope[73:42], zero padding[79:74]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // next_col[5:0], next_row[11:6], next_frac_col[28:12],
  // next_frac_row[45:29], zero padding[47:46]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // outside_grid[0], saturated[1]
  output logic [USER_W-1:0]      m_axis_tuser
);

  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope;
    logic [FRAC_W-1:0]         frac_row;
    logic [FRAC_W-1:0]         frac_col;
    logic [CELL_W-1:0]         row;
    logic [CELL_W-1:0]         col;
  } in_word_t;

  typedef struct packed {
    logic [FRAC_W-1:0]       frac_row;
    logic [FRAC_W-1:0]       frac_col;
    logic signed [IDX_W-1:0] row;
    logic signed [IDX_W-1:0] col;
  } out_word_t;

  in_word_t  in_w;
  out_word_t out_w;

  logic    front_valid, front_ready;
  front_t  front_w;
  logic    canon_valid, canon_ready;
  canon_t  canon_w;
  logic    exit_valid, exit_ready;
  exit_t   exit_w;
  result_t res_w;

  assign in_w = s_axis_tdata[IN_W-1:0];

  // Edge selection, clamping and the slope magnitude.
  gcres_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .cell_col_i   (in_w.col),
    .cell_row_i   (in_w.row),
    .frac_col_i   (in_w.frac_col),
    .frac_row_i   (in_w.frac_row),
    .cell_slope_i (in_w.slope),
    .out_valid_o  (front_valid),
    .out_ready_i  (front_ready),
    .out_o        (front_w)
  );

  // Slope in the canonical left-edge frame.
  gcres_recip u_recip (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_i        (front_w),
    .out_valid_o (canon_valid),
    .out_ready_i (canon_ready),
    .out_o       (canon_w)
  );

  // Exit edge and the exit position along it.
  gcres_exit u_exit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (canon_valid),
    .in_ready_o  (canon_ready),
    .in_i        (canon_w),
    .out_valid_o (exit_valid),
    .out_ready_i (exit_ready),
    .out_o       (exit_w)
  );

  // Rotation back to the grid frame and the output register.
  gcres_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (exit_valid),
    .in_ready_o  (exit_ready),
    .in_i        (exit_w),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res_w)
  );

  always_comb begin
    out_w.col      = res_w.col;
    out_w.row      = res_w.row;
    out_w.frac_col = res_w.frac_col;
    out_w.frac_row = res_w.frac_row;
  end

  assign m_axis_tdata = {{(OUT_TDATA_W-OUT_W){1'b0}}, out_w};
  assign m_axis_tuser = {res_w.sat, res_w.outside};

  // An empty front stage must always take a request.
  `GCRES_ASSERT_HOLDS(a_front_empty_ready, !front_valid, s_axis_tready, "front stage empty but request refused")

  // An accepted request lands in the front stage.
  `GCRES_ASSERT_NEXT(a_accept_lands, s_axis_tvalid && s_axis_tready, front_valid, "accepted request lost at the front stage")

  // A step onto the ring just beyond the grid must be flagged.
  `GCRES_ASSERT_HOLDS(a_ring_outside, m_axis_tvalid && (res_w.col == IDX_BELOW || res_w.col == GRID_LIMIT || res_w.row == IDX_BELOW || res_w.row == GRID_LIMIT), res_w.outside, "cell beyond the grid not flagged")

endmodule

FILE: hw/rtl/gcres_front.sv
// ---------------------------------------------------------------------------
// Grid cell ray exit step: front stage
// Clamps the fractions, picks the entry edge and the canonical entry height.
// ---------------------------------------------------------------------------
module gcres_front import gcres_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [CELL_W-1:0]         cell_col_i,
  input  logic [CELL_W-1:0]         cell_row_i,
  input  logic [FRAC_W-1:0]         frac_col_i,
  input  logic [FRAC_W-1:0]         frac_row_i,
  input  logic signed [SLOPE_W-1:0] cell_slope_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output front_t                    out_o
);

  logic              valid_q;
  front_t            data_q, data_d;
  logic [FRAC_W-1:0] fx, fy;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    fx = (frac_col_i > FRAC_ONE) ? FRAC_ONE : frac_col_i;
    fy = (frac_row_i > FRAC_ONE) ? FRAC_ONE : frac_row_i;
    data_d.loc.col = cell_col_i;
    data_d.loc.row = cell_row_i;
    data_d.slope   = cell_slope_i;
    data_d.mag     = cell_slope_i[SLOPE_W-1] ? -cell_slope_i : cell_slope_i;
    priority if (fy == FRAC_ONE) begin
      data_d.loc.side = EDGE_TOP;
      data_d.y        = fx;
    end else if (fx == FRAC_ONE) begin
      data_d.loc.side = EDGE_RIGHT;
      data_d.y        = FRAC_ONE - fy;
    end else if (fy == '0) begin
      data_d.loc.side = EDGE_BOTTOM;
      data_d.y        = FRAC_ONE - fx;
    end else begin
      data_d.loc.side = EDGE_LEFT;
      data_d.y        = fy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

FILE: hw/rtl/gcres_recip.sv
// ---------------------------------------------------------------------------
// Grid cell ray exit step: reciprocal pipeline
// Pipelined restoring divider for ONE*ONE / |slope|, one quotient bit per
// stage; a final stage forms the canonical slope, -1/slope on top or bottom.
// ---------------------------------------------------------------------------
module gcres_recip import gcres_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  front_t in_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output canon_t out_o
);

  typedef struct packed {
    front_t             f;
    logic [REM_W-1:0]   rem;
    logic [SLOPE_W-1:0] quo;
  } recip_t;

  logic [RECIP_STEPS:0]   v_q;
  logic [RECIP_STEPS:0]   src_v;
  logic [RECIP_STEPS+1:0] rdy;
  recip_t                 st_q [RECIP_STEPS];
  recip_t                 last;
  canon_t                 fin_q, fin_d;

  // Stage RECIP_STEPS is the finishing stage; a stage may load when it is
  // empty or when the stage after it moves on.
  assign src_v               = {v_q[RECIP_STEPS-1:0], in_valid_i};
  assign rdy[RECIP_STEPS+1]  = out_ready_i;

  for (genvar k = 0; k <= RECIP_STEPS; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k <= RECIP_STEPS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= src_v[k];
        end
      end
    end
  end

  for (genvar k = 0; k < RECIP_STEPS; k++) begin : g_step
    recip_t    src;
    recip_t    nxt;
    div_step_t res;

    if (k == 0) begin : g_head
      // The dividend is a one followed by zeros; its leading one is the
      // starting remainder.
      always_comb begin
        src.f   = in_i;
        src.rem = REM_W'(1);
        src.quo = '0;
      end
    end else begin : g_body
      assign src = st_q[k-1];
    end

    assign res = div_step(src.rem, 1'b0, src.f.mag);

    always_comb begin
      nxt     = src;
      nxt.rem = res.rem;
      nxt.quo = {src.quo[SLOPE_W-2:0], res.q};
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && src_v[k]) begin
        st_q[k] <= nxt;
      end
    end
  end

  assign last = st_q[RECIP_STEPS-1];

  always_comb begin
    fin_d.loc   = last.f.loc;
    fin_d.y     = last.f.y;
    fin_d.slope = last.f.slope;
    fin_d.sat   = 1'b0;
    if (last.f.loc.side == EDGE_TOP || last.f.loc.side == EDGE_BOTTOM) begin
      priority if (last.f.mag == '0) begin
        fin_d.slope = SLOPE_MIN;
        fin_d.sat   = 1'b1;
      end else if (!last.f.slope[SLOPE_W-1]) begin
        if (last.f.mag <= RECIP_POS_LIMIT) begin
          fin_d.slope = SLOPE_MIN;
          fin_d.sat   = 1'b1;
        end else begin
          fin_d.slope = -last.quo;
        end
      end else begin
        if (last.f.mag <= RECIP_NEG_LIMIT) begin
          fin_d.slope = SLOPE_MAX;
          fin_d.sat   = 1'b1;
        end else begin
          fin_d.slope = last.quo;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[RECIP_STEPS] && src_v[RECIP_STEPS]) begin
      fin_q <= fin_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[RECIP_STEPS];
  assign out_o       = fin_q;

endmodule

FILE: hw/rtl/gcres_exit.sv
// ---------------------------------------------------------------------------
// Grid cell ray exit step: exit edge and position
// Chooses the exit edge in the canonical frame, then runs a pipelined
// restoring divider for the exit position on the bottom or top edge.
// ---------------------------------------------------------------------------
module gcres_exit import gcres_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  canon_t in_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output exit_t  out_o
);

  typedef struct packed {
    cell_t             loc;
    exit_e             dir;
    logic              x_one;
    logic [FRAC_W-1:0] y;
    logic              sat;
    logic              n0;
    logic [REM_W-1:0]  den;
    logic [REM_W-1:0]  rem;
    logic [FRAC_W-1:0] quo;
  } xst_t;

  logic [EXIT_STAGES-1:0]      v_q;
  logic [EXIT_STAGES-1:0]      src_v;
  logic [EXIT_STAGES:0]        rdy;
  xst_t                        st_q [EXIT_STAGES];
  xst_t                        setup_d;
  xst_t                        last;
  logic signed [SLOPE_W+1:0]   sl_e, y_e, one_e, neg_sl;
  logic [FRAC_W-1:0]           num;

  assign src_v              = {v_q[EXIT_STAGES-2:0], in_valid_i};
  assign rdy[EXIT_STAGES]   = out_ready_i;

  for (genvar k = 0; k < EXIT_STAGES; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < EXIT_STAGES; k++) begin
        if (rdy[k]) begin
          v_q[k] <= src_v[k];
        end
      end
    end
  end

  // Setup: the line leaves through the bottom if it falls below zero within
  // the cell, through the right if it stays under one, else through the top.
  always_comb begin
    sl_e   = {{2{in_i.slope[SLOPE_W-1]}}, in_i.slope};
    y_e    = (SLOPE_W+2)'(in_i.y);
    one_e  = (SLOPE_W+2)'(FRAC_ONE);
    neg_sl = -sl_e;

    setup_d.loc   = in_i.loc;
    setup_d.sat   = in_i.sat;
    setup_d.rem   = '0;
    setup_d.quo   = '0;
    setup_d.x_one = 1'b0;
    setup_d.den   = in_i.slope;
    num           = '0;
    priority if (sl_e < -y_e) begin
      setup_d.dir = EXIT_BOTTOM;
      setup_d.y   = '0;
      setup_d.den = neg_sl[REM_W-1:0];
      num         = in_i.y;
    end else if (sl_e < one_e - y_e) begin
      setup_d.dir   = EXIT_RIGHT;
      setup_d.y     = in_i.y + in_i.slope[FRAC_W-1:0];
      setup_d.x_one = 1'b1;
    end else begin
      setup_d.dir = EXIT_TOP;
      setup_d.y   = FRAC_ONE;
      num         = FRAC_ONE - in_i.y;
      if (in_i.slope == '0) begin
        // Level line from the top-left corner: the exit is the top-right one.
        setup_d.x_one = 1'b1;
        setup_d.sat   = 1'b1;
      end
    end
    // Dividend is num shifted up by FRAC_BITS; all but its lowest bit of num
    // already form the starting remainder, the lowest enters at the first step.
    setup_d.rem = REM_W'(num >> 1);
    setup_d.n0  = num[0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && src_v[0]) begin
      st_q[0] <= setup_d;
    end
  end

  for (genvar k = 1; k < EXIT_STAGES; k++) begin : g_step
    xst_t      nxt;
    div_step_t res;

    assign res = div_step(st_q[k-1].rem, st_q[k-1].n0, st_q[k-1].den);

    always_comb begin
      nxt     = st_q[k-1];
      nxt.rem = res.rem;
      nxt.n0  = 1'b0;
      nxt.quo = {st_q[k-1].quo[FRAC_W-2:0], res.q};
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && src_v[k]) begin
        st_q[k] <= nxt;
      end
    end
  end

  assign last = st_q[EXIT_STAGES-1];

  always_comb begin
    out_o.loc = last.loc;
    out_o.dir = last.dir;
    out_o.x   = last.x_one ? FRAC_ONE : last.quo;
    out_o.y   = last.y;
    out_o.sat = last.sat;
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[EXIT_STAGES-1];

endmodule

FILE: hw/rtl/gcres_back.sv
// ---------------------------------------------------------------------------
// Grid cell ray exit step: output stage
// Rotates the exit back into the grid frame, steps into the neighbouring
// cell and holds the result in the output register.
// ---------------------------------------------------------------------------
module gcres_back import gcres_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  exit_t   in_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  logic              valid_q;
  result_t           res_q, res_d;
  logic signed [1:0] di, dj, di_r, dj_r;
  logic [FRAC_W-1:0] x_r, y_r;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    unique case (in_i.dir)
      EXIT_BOTTOM: begin
        di = 2'sd0;
        dj = -2'sd1;
      end
      EXIT_RIGHT: begin
        di = 2'sd1;
        dj = 2'sd0;
      end
      EXIT_TOP: begin
        di = 2'sd0;
        dj = 2'sd1;
      end
      default: begin
        di = 2'sd0;
        dj = 2'sd0;
      end
    endcase

    unique case (in_i.loc.side)
      EDGE_LEFT: begin
        di_r = di;
        dj_r = dj;
        x_r  = in_i.x;
        y_r  = in_i.y;
      end
      EDGE_TOP: begin
        di_r = dj;
        dj_r = -di;
        x_r  = in_i.y;
        y_r  = FRAC_ONE - in_i.x;
      end
      EDGE_RIGHT: begin
        di_r = -di;
        dj_r = -dj;
        x_r  = FRAC_ONE - in_i.x;
        y_r  = FRAC_ONE - in_i.y;
      end
      default: begin
        di_r = -dj;
        dj_r = di;
        x_r  = FRAC_ONE - in_i.y;
        y_r  = in_i.x;
      end
    endcase

    // Adding or removing ONE modulo twice ONE just flips the top bit.
    res_d.frac_col = x_r ^ (FRAC_W'(di_r != 2'sd0) << FRAC_BITS);
    res_d.frac_row = y_r ^ (FRAC_W'(dj_r != 2'sd0) << FRAC_BITS);
    res_d.col      = IDX_W'(in_i.loc.col) + IDX_W'(di_r);
    res_d.row      = IDX_W'(in_i.loc.row) + IDX_W'(dj_r);
    res_d.outside  = (res_d.col < 0) || (res_d.col >= GRID_LIMIT) ||
                     (res_d.row < 0) || (res_d.row >= GRID_LIMIT);
    res_d.sat      = in_i.sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule
